// File: design/mf3_pkg.sv
package mf3_pkg;

  // Line store geometry
  localparam int MaxWidth  = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int MaxHeight = 4096;
  localparam int MinDim    = 3;

  // Configuration register widths
  localparam int WidthW   = 11;
  localparam int HeightW  = 13;
  localparam int RowW     = 13;   // row counter runs to height + 1 during the tail
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 13;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Control that travels with a word from the line store read to the result register
  typedef struct packed {
    logic            emit;      // word produces a result
    logic            interior;  // result is a median, else the center passes through
    logic            last;      // result is the final pixel of the frame
    logic [ColW-1:0] col;       // line store column, for the upper store write-back
  } stage_ctrl_t;

endpackage

// File: design/mf3_median9.sv
module mf3_median9 (
  input  mf3_pkg::chan_t taps_i [9],
  output mf3_pkg::chan_t median_o
);
  import mf3_pkg::*;

  chan_t lo [3];
  chan_t md [3];
  chan_t hi [3];
  chan_t max_lo;
  chan_t med_md;
  chan_t min_hi;

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sort each row of three, then the median of nine is the median of
  // (largest low, median of mids, smallest high).
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo[r] = min2(min2(taps_i[3*r], taps_i[3*r+1]), taps_i[3*r+2]);
      hi[r] = max2(max2(taps_i[3*r], taps_i[3*r+1]), taps_i[3*r+2]);
      md[r] = med3(taps_i[3*r], taps_i[3*r+1], taps_i[3*r+2]);
    end
    max_lo   = max2(max2(lo[0], lo[1]), lo[2]);
    min_hi   = min2(min2(hi[0], hi[1]), hi[2]);
    med_md   = med3(md[0], md[1], md[2]);
    median_o = med3(max_lo, med_md, min_hi);
  end

endmodule

// File: design/median_filter_3x3_rgb.sv
// 3x3 RGB median filter for a raster-order pixel stream. Send the W*H pixel
// words of a frame (op = pixel), then W+1 drain words (op = drain) to flush
// the tail; each result comes out one row plus one pixel after its input and
// the final one carries last_of_frame. Interior pixels get the per-channel
// median of the nine original pixels around them; the first and last rows
// and columns pass through unchanged. Width is clamped to 3..1024 and height
// to 3..4096; a write to either register restarts the frame. Drain words
// during a frame and pixel words during the tail are taken and dropped.
// Rate: one word per clock, sustained, whenever the output side takes a word
// per clock. Inside, a word goes from the single-port-read line store access
// into stage 1, then through the window shift and median network feeding the
// result register. The line stores need no clearing after reset.
module median_filter_3x3_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic                          last_of_frame_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mf3_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mf3_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mf3_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic               cfg_fire;

  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WidthW-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WidthW'(MinDim)) begin
      w_eff = WidthW'(MinDim);
    end else if (width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q < HeightW'(MinDim)) begin
      h_eff = HeightW'(MinDim);
    end else if (height_q > HeightW'(MaxHeight)) begin
      h_eff = HeightW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic        s1_valid_q;
  stage_ctrl_t s1_ctrl_q;
  pixel_t      s1_pix_q;
  logic        out_valid_q;
  logic        s1_adv;      // stage 1 may hand its word on
  logic        s1_move;     // stage 1 word actually moves this cycle
  logic        in_fire;
  logic        take;        // accepted word that updates state

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Input position counters
  // ---------------------------------------------------------------------
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    ci;
  logic               in_frame;
  logic [RowW-1:0]    ro;
  logic [WidthW-1:0]  co;
  logic [WidthW-1:0]  ci_next;
  stage_ctrl_t        ctrl_in;
  pixel_t             pix_in;

  always_comb begin
    in_frame = row_q < RowW'(h_eff);
    take     = in_fire && ((op_e'(op_i) == OP_PIXEL) ? in_frame : !in_frame);

    ci = (WidthW'(col_q) >= w_eff) ? '0 : col_q;

    // drain words push black through the stores; it only reaches borders
    pix_in = (op_e'(op_i) == OP_DRAIN) ? '0 : pixel_t'{in_red_i, in_green_i, in_blue_i};

    // output position: one row and one pixel behind the input
    if (ci != '0) begin
      ro = row_q - RowW'(1);
      co = WidthW'(ci) - WidthW'(1);
    end else begin
      ro = row_q - RowW'(2);
      co = w_eff - WidthW'(1);
    end

    ctrl_in.emit     = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && (ci != '0));
    ctrl_in.interior = (ro != '0) && ((ro + RowW'(2)) <= RowW'(h_eff))
                    && (co != '0) && ((co + WidthW'(2)) <= w_eff);
    ctrl_in.last     = (ci == '0) && (row_q == RowW'(h_eff) + RowW'(1));
    ctrl_in.col      = ci;

    ci_next = WidthW'(ci) + WidthW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_fire) begin
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (ctrl_in.last) begin
        col_d = '0;
        row_d = '0;
      end else if (ci_next >= w_eff) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = ci_next[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: middle holds the row above, upper the row two above.
  // Middle is written with the new pixel as it is read; upper gets the
  // old middle value from the registered read data when stage 1 moves on.
  // ---------------------------------------------------------------------
  pixel_t upper_mem  [MaxWidth];
  pixel_t middle_mem [MaxWidth];
  pixel_t up_rd_q;
  pixel_t mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      up_rd_q        <= upper_mem[ci];
      mid_rd_q       <= middle_mem[ci];
      middle_mem[ci] <= pix_in;
    end
    if (s1_move) begin
      upper_mem[s1_ctrl_q.col] <= mid_rd_q;
    end
  end

  // stage 1 register
  logic s1_valid_d;

  always_comb begin
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctrl_q <= ctrl_in;
      s1_pix_q  <= pix_in;
    end
  end

  // ---------------------------------------------------------------------
  // 3x3 window: index r*3+c, column 2 is the newest
  // ---------------------------------------------------------------------
  pixel_t win_q    [9];
  pixel_t win_next [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win_q[r*3+1];
      win_next[r*3+1] = win_q[r*3+2];
    end
    win_next[2] = up_rd_q;
    win_next[5] = mid_rd_q;
    win_next[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_move) begin
      win_q <= win_next;
    end
  end

  // per-channel median networks
  chan_t  red_taps   [9];
  chan_t  green_taps [9];
  chan_t  blue_taps  [9];
  chan_t  med_red;
  chan_t  med_green;
  chan_t  med_blue;
  pixel_t med;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      red_taps[i]   = win_next[i].red;
      green_taps[i] = win_next[i].green;
      blue_taps[i]  = win_next[i].blue;
    end
  end

  mf3_median9 u_med_red (
    .taps_i   (red_taps),
    .median_o (med_red)
  );

  mf3_median9 u_med_green (
    .taps_i   (green_taps),
    .median_o (med_green)
  );

  mf3_median9 u_med_blue (
    .taps_i   (blue_taps),
    .median_o (med_blue)
  );

  assign med = {med_red, med_green, med_blue};

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic   out_valid_d;
  pixel_t out_pix_q;
  logic   out_last_q;

  always_comb begin
    if (s1_move) begin
      out_valid_d = s1_ctrl_q.emit;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_ctrl_q.emit) begin
      out_pix_q  <= s1_ctrl_q.interior ? med : win_next[4];
      out_last_q <= s1_ctrl_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_pix_q.red;
  assign out_green_o     = out_pix_q.green;
  assign out_blue_o      = out_pix_q.blue;
  assign last_of_frame_o = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WidthW'(col_q) < w_eff)
    else $error("input column beyond frame width");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ctrl_in.last |=> (col_q == '0) && (row_q == '0))
    else $error("frame counters not cleared after last word");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_ctrl_q) && $stable(s1_pix_q))
    else $error("stage 1 word lost while output stalled");

endmodule

// File: sim/tb_median_filter_3x3_rgb.sv
`timescale 1ns / 100ps

module tb_median_filter_3x3_rgb;
  import mf3_pkg::*;

  // Upper bound on run length.
  localparam int unsigned LimitCycles  = 2_000_000;
  // Lets a dropped word still in flight inside the block settle after the last owed result.
  localparam int unsigned SettleCycles = 8;
  // Stop the random phase after this many frame pixels were taken.
  localparam int unsigned RandomPixels = 300;
  // Cap on reported mismatches, so a broken build does not flood the log.
  localparam int          MaxReports   = 30;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } filtered_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [7:0]          in_red_i;
  logic [7:0]          in_green_i;
  logic [7:0]          in_blue_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          out_red_o;
  logic [7:0]          out_green_o;
  logic [7:0]          out_blue_o;
  logic                last_of_frame_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  median_filter_3x3_rgb uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .last_of_frame_o(last_of_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Filter state as the testbench sees it: line stores, 3x3 window, counters
  // and the raw register values. Updated at the edge where a word is taken.
  // ---------------------------------------------------------------------------
  pixel_t      upper_line  [MaxWidth];
  pixel_t      middle_line [MaxWidth];
  pixel_t      win_px      [9];       // row-major, column 2 is the newest
  int unsigned col_in;
  int unsigned row_in;
  int unsigned pos_out;
  int unsigned width_reg;
  int unsigned height_reg;

  filtered_t   filtered_q[$];         // results owed by the block, oldest first
  int          mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned pixels_taken = 0;      // frame pixels that entered the filter
  bit          gaps_on;               // sender inserts random gaps
  bit          stalls_on;             // receiver inserts random stalls

  function automatic int unsigned active_width();
    if (width_reg < MinDim) return MinDim;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < MinDim) return MinDim;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  // Median by rank: the value with at most four below it and at least five at or below.
  function automatic chan_t median_of_nine(input logic [8:0][7:0] v);
    int    below;
    int    at_or_below;
    chan_t med;
    med = '0;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      at_or_below = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        if (v[j] <= v[i]) at_or_below++;
      end
      if (below <= 4 && at_or_below >= 5) med = v[i];
    end
    return med;
  endfunction

  // Advance the filter by one taken word; queue the result it releases, if any.
  // Returns 0 when the word is dropped (drain mid-frame, pixel in the tail).
  function automatic bit predict_filtered_pixel(input op_e op, input pixel_t px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     ci;
    int              ro;
    int              co;
    pixel_t          pix;
    pixel_t          up_px;
    pixel_t          mid_px;
    pixel_t          res;
    logic [8:0][7:0] rv;
    logic [8:0][7:0] gv;
    logic [8:0][7:0] bv;
    bit              emit;
    filtered_t       item;
    w = active_width();
    h = active_height();
    // pixels belong to the frame, drains to the tail; anything else is dropped
    if ((op == OP_PIXEL) != (row_in < h)) return 1'b0;
    pix = (op == OP_DRAIN) ? pixel_t'('0) : px;
    ci  = (col_in >= w) ? 0 : col_in;

    up_px  = upper_line[ci];
    mid_px = middle_line[ci];
    upper_line[ci]  = mid_px;
    middle_line[ci] = pix;
    for (int r = 0; r < 3; r++) begin
      win_px[r*3]   = win_px[r*3+1];
      win_px[r*3+1] = win_px[r*3+2];
    end
    win_px[2] = up_px;
    win_px[5] = mid_px;
    win_px[8] = pix;

    // the window center lags the input by one row and one column
    emit = row_in >= 2 || (row_in == 1 && ci >= 1);
    if (ci >= 1) begin
      ro = int'(row_in) - 1;
      co = int'(ci) - 1;
    end else begin
      ro = int'(row_in) - 2;
      co = int'(w) - 1;
    end
    if (ci + 1 >= w) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in = ci + 1;
    end
    if (!emit) return 1'b1;

    if (ro >= 1 && ro + 2 <= int'(h) && co >= 1 && co + 2 <= int'(w)) begin
      for (int k = 0; k < 9; k++) begin
        rv[k] = win_px[k].red;
        gv[k] = win_px[k].green;
        bv[k] = win_px[k].blue;
      end
      res.red   = median_of_nine(rv);
      res.green = median_of_nine(gv);
      res.blue  = median_of_nine(bv);
    end else begin
      res = win_px[4];   // border passes through
    end
    item.pix  = res;
    item.last = pos_out >= w * h - 1;
    pos_out++;
    filtered_q.push_back(item);
    if (item.last) begin
      col_in  = 0;
      row_in  = 0;
      pos_out = 0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------
  function automatic pixel_t rand_pixel(input bit narrow);
    pixel_t px;
    // narrow content: four levels per channel, so medians see many ties
    if (narrow) begin
      px.red   = 8'($urandom_range(0, 3) * 85);
      px.green = 8'($urandom_range(0, 3) * 85);
      px.blue  = 8'($urandom_range(0, 3) * 85);
    end else begin
      px = pixel_t'($urandom_range(0, 24'hFF_FFFF));
    end
    return px;
  endfunction

  // One input word: optional gap, hold until taken, then update the prediction.
  task automatic send_word(input op_e op, input pixel_t px);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    in_red_i   <= px.red;
    in_green_i <= px.green;
    in_blue_i  <= px.blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_filtered_pixel(op, px) && op == OP_PIXEL) pixels_taken++;
  endtask

  // Idle the input, let every owed result arrive, then let dropped words settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; any write restarts the frame counters.
  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = data[WidthW-1:0];
    else height_reg = data[HeightW-1:0];
    col_in  = 0;
    row_in  = 0;
    pos_out = 0;
  endtask

  // Full frame at the current size plus the W+1 drain words. With noise on,
  // a dropped drain mid-frame, a dropped pixel in the tail and a surplus
  // drain after the frame may be mixed in.
  task automatic send_frame(input bit narrow, input bit noisy);
    int unsigned w;
    int unsigned h;
    int          stray_at;
    w = active_width();
    h = active_height();
    stray_at = (noisy && $urandom_range(0, 5) == 0) ? int'($urandom_range(0, w * h - 1)) : -1;
    for (int i = 0; i < int'(w * h); i++) begin
      if (i == stray_at) send_word(OP_DRAIN, rand_pixel(1'b0));
      send_word(OP_PIXEL, rand_pixel(narrow));
    end
    if (noisy && $urandom_range(0, 5) == 0) send_word(OP_PIXEL, rand_pixel(1'b0));
    for (int i = 0; i <= int'(w); i++) send_word(OP_DRAIN, rand_pixel(1'b0));
    if (noisy && $urandom_range(0, 5) == 0) send_word(OP_DRAIN, rand_pixel(1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset size 640x480: one row and three pixels, so the first two top-border
  // results show the reset width; the frame is cut off by the next register write.
  task automatic test_reset_geometry();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < 640 + 3; i++) send_word(OP_PIXEL, rand_pixel(i[0]));
  endtask

  // Smallest frame via too-small register values (clamped to 3x3), channel
  // extremes, a drain mid-frame, a pixel in the tail, a surplus drain.
  task automatic test_directed_frame();
    logic [0:8][23:0] pat;
    pat = {24'h000000, 24'hFFFFFF, 24'hFF00FF,
           24'h00FF00, 24'h808080, 24'h7F7F7F,
           24'h0000FF, 24'hFFFF00, 24'h010101};
    cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(2));
    cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(0));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i == 5) send_word(OP_DRAIN, pixel_t'(24'hFFFFFF));
      send_word(OP_PIXEL, pixel_t'(pat[i]));
    end
    send_word(OP_PIXEL, pixel_t'(24'h5A5A5A));
    for (int i = 0; i < 4; i++) send_word(OP_DRAIN, pixel_t'(24'hA5A5A5));
    send_word(OP_DRAIN, pixel_t'(24'h000000));
  endtask

  // A register write part way into a frame: counters restart, stores keep.
  task automatic test_restart_on_write();
    cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(3));
    cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(1));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < 4; i++) send_word(OP_PIXEL, rand_pixel(1'b0));
    cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(3));
    send_frame(1'b0, 1'b0);
  endtask

  // Wide, short frame: many columns through the line stores.
  task automatic test_wide_frame();
    cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(40));
    cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(3));
    gaps_on   = 1'b1;
    stalls_on = 1'b0;
    send_frame(1'b0, 1'b0);
  endtask

  // Tall frame at the narrowest width.
  task automatic test_tall_frame();
    cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(3));
    cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(40));
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    send_frame(1'b1, 1'b0);
  endtask

  // Small random frames with random content, sizes, idling and noise;
  // now and then a frame is cut short by a register write.
  task automatic test_random_frames();
    int unsigned start;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned cut;
    bit          narrow;
    start = pixels_taken;
    while (pixels_taken - start < RandomPixels) begin
      w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      if (w_raw != width_reg || $urandom_range(0, 3) == 0)
        cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(w_raw));
      if (h_raw != height_reg || $urandom_range(0, 3) == 0)
        cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(h_raw));
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      narrow    = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, active_width() * active_height() - 1);
        for (int i = 0; i < int'(cut); i++) send_word(OP_PIXEL, rand_pixel(narrow));
        cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(height_reg));
      end else begin
        send_frame(narrow, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side: random stalls, one draw per word
  // ---------------------------------------------------------------------------
  initial begin : drive_out_ready
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = stalls_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (mismatch_cnt < MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Each result word taken is matched against the oldest owed result.
  always @(posedge clk_i) begin : check_results
    filtered_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_q.size() == 0) begin
        if (mismatch_cnt < MaxReports)
          $display("%0t: unexpected result word, expected none, actual %0h %0h %0h %0b",
                   $time, out_red_o, out_green_o, out_blue_o, last_of_frame_o);
        mismatch_cnt++;
      end else begin
        want = filtered_q.pop_front();
        check_field("out_red", want.pix.red, out_red_o);
        check_field("out_green", want.pix.green, out_green_o);
        check_field("out_blue", want.pix.blue, out_blue_o);
        check_field("last_of_frame", 8'(want.last), 8'(last_of_frame_o));
      end
    end
  end

  // Watchdog: a hang or a result that never comes ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LimitCycles) begin
      $display("[median_filter_3x3_rgb] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_PIXEL;
    in_red_i    = '0;
    in_green_i  = '0;
    in_blue_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    // filter state after reset; unwritten store entries never reach a result
    for (int i = 0; i < MaxWidth; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_px[i] = '0;
    col_in     = 0;
    row_in     = 0;
    pos_out    = 0;
    width_reg  = WidthReset;
    height_reg = HeightReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_directed_frame();
    test_restart_on_write();
    test_wide_frame();
    test_tall_frame();
    test_random_frames();

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("[median_filter_3x3_rgb] OK");
    end else begin
      $display("[median_filter_3x3_rgb] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mf3_pkg.sv
design/mf3_median9.sv
design/median_filter_3x3_rgb.sv
sim/tb_median_filter_3x3_rgb.sv
